// ===== src/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// No dependencies; every other file in src except fpba_ram refers to this package by scoped name.
`default_nettype none

package fpba_pkg;

  // Default sizing of the free-size table
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  // Fixed port field widths
  localparam int IDX_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int MODE_W       = 2;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // Selection policies (code 3 falls back to first fit)
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_wr;   // write a load beat into the table
    logic start;     // latch an allocate request, reset the scan
    logic scan_rd;   // issue one table read
    logic wb;        // write back the pick and fill the output register
  } fpba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;  // no entries in use
    logic scan_last;   // current read is the last entry in use
    logic out_busy;    // output register holds a beat that is not taken now
  } fpba_sts_t;

endpackage

`default_nettype wire

// ===== src/fpba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/fpba_ctrl.sv =====
// Controller state machine for the allocator: accept, scan, drain, write back.
// Depends on fpba_pkg (state, command and status types, opcodes).
`default_nettype none

module fpba_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  output logic                     in_stall,
  output fpba_pkg::fpba_cmd_t      cmd,
  input  wire fpba_pkg::fpba_sts_t sts
);

  fpba_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpba_pkg::ST_IDLE: begin
        if (in_valid && (in_op == fpba_pkg::OP_ALLOC)) begin
          state_nxt = sts.count_zero ? fpba_pkg::ST_WB : fpba_pkg::ST_SCAN;
        end
      end
      fpba_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = fpba_pkg::ST_DRAIN;
        end
      end
      fpba_pkg::ST_DRAIN: begin
        state_nxt = fpba_pkg::ST_WB;
      end
      fpba_pkg::ST_WB: begin
        if (!sts.out_busy) begin
          state_nxt = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      fpba_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_wr   = in_valid && (in_op == fpba_pkg::OP_LOAD);
        cmd.start     = in_valid && (in_op == fpba_pkg::OP_ALLOC);
      end
      fpba_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      fpba_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      fpba_pkg::ST_WB: begin
        cmd.wb = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/fpba_dpath.sv =====
// Datapath: config registers, free-size table, scan compare, pick registers, output beat.
// Depends on fpba_pkg and fpba_ram.
`default_nettype none

module fpba_dpath #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_valid,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input item payload
  input  wire logic [fpba_pkg::IDX_FIELD_W-1:0]    in_load_index,
  input  wire logic [fpba_pkg::SIZE_FIELD_W-1:0]   in_size,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_granted,
  output logic [fpba_pkg::IDX_FIELD_W-1:0]         out_chosen_block,
  output logic [fpba_pkg::SIZE_FIELD_W-1:0]        out_remaining_after,
  // controller link
  input  wire fpba_pkg::fpba_cmd_t                 cmd,
  output fpba_pkg::fpba_sts_t                      sts
);

  localparam int          IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [31:0] NB32  = 32'(NUM_BLOCKS);

  // config registers
  logic [fpba_pkg::MODE_W-1:0]  fit_mode_r;
  logic [fpba_pkg::COUNT_W-1:0] block_count_r;

  // scan and pick state
  logic [SIZE_WIDTH-1:0] req_r;
  logic [IDX_W-1:0]      last_idx_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  cmp_vld_r;
  logic                  have_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [SIZE_WIDTH-1:0] best_val_r;

  // output beat
  logic                                 out_valid_r;
  logic                                 out_granted_r;
  logic [fpba_pkg::IDX_FIELD_W-1:0]     out_chosen_r;
  logic [fpba_pkg::SIZE_FIELD_W-1:0]    out_remain_r;

  logic [SIZE_WIDTH-1:0] rd_data;
  logic [SIZE_WIDTH-1:0] new_val;
  logic [31:0]           count32;
  logic [31:0]           last32;
  logic                  load_ok;
  logic                  fits;
  logic                  better;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SIZE_WIDTH-1:0] ram_wdata;

  // configuration writes; ready is always high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= fpba_pkg::MODE_FIRST;
      block_count_r <= fpba_pkg::COUNT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == fpba_pkg::CFG_FIT_MODE) begin
        fit_mode_r <= cfg_data[fpba_pkg::MODE_W-1:0];
      end else if (cfg_index == fpba_pkg::CFG_BLOCK_COUNT) begin
        block_count_r <= cfg_data[fpba_pkg::COUNT_W-1:0];
      end
    end
  end

  // last entry in use, count saturated at table depth
  assign count32 = 32'(block_count_r);
  assign last32  = (count32 > NB32) ? (NB32 - 32'd1) : (count32 - 32'd1);

  // loads outside the table are dropped
  assign load_ok = cmd.load_wr && (32'(in_load_index) < NB32);
  assign new_val = best_val_r - req_r;

  // table write mux: load beats or write back of the pick
  assign ram_we    = load_ok || (cmd.wb && have_r);
  assign ram_waddr = cmd.wb ? best_idx_r : IDX_W'(in_load_index);
  assign ram_wdata = cmd.wb ? new_val : SIZE_WIDTH'(in_size);

  fpba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (NUM_BLOCKS),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_rd),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  // candidate compare against the current pick
  always_comb begin
    fits   = rd_data >= req_r;
    better = !have_r;
    if (fit_mode_r == fpba_pkg::MODE_BEST) begin
      better = better || (rd_data < best_val_r);
    end else if (fit_mode_r == fpba_pkg::MODE_WORST) begin
      better = better || (rd_data > best_val_r);
    end
  end

  // scan counter and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      have_r    <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.start) begin
        have_r <= 1'b0;
      end else if (cmp_vld_r && fits && better) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r      <= SIZE_WIDTH'(in_size);
      last_idx_r <= IDX_W'(last32);
      rd_idx_r   <= '0;
    end else if (cmd.scan_rd) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    if (cmd.scan_rd) begin
      cmp_idx_r <= rd_idx_r;
    end
    if (cmp_vld_r && fits && better) begin
      best_idx_r <= cmp_idx_r;
      best_val_r <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_granted_r <= have_r;
      out_chosen_r  <= have_r ? fpba_pkg::IDX_FIELD_W'(best_idx_r) : '0;
      out_remain_r  <= have_r ? fpba_pkg::SIZE_FIELD_W'(new_val) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted         = out_granted_r;
  assign out_chosen_block    = out_chosen_r;
  assign out_remaining_after = out_remain_r;

  // status to controller
  assign sts.count_zero = (block_count_r == '0);
  assign sts.scan_last  = (rd_idx_r == last_idx_r);
  assign sts.out_busy   = out_valid_r && out_stall;

endmodule

`default_nettype wire

// ===== src/fit_policy_block_allocator.sv =====
// Load beats give no result; they are accepted back to back.
// An allocate beat with N = min(block_count, NUM_BLOCKS) > 0 entries in use is scanned by the
// table read port, visiting one entry per cycle, then drains; the pick is written back, the
// result registered, and the next beat accepted after write back. With N = 0 the scan is skipped.
// Write back waits while a stalled earlier result holds the output.
// Sync active-low reset clears control, fit_mode (first fit), block_count (1); table undefined.
`default_nettype none

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_op,
  input  wire logic [fpba_pkg::IDX_FIELD_W-1:0]    in_load_index,
  input  wire logic [fpba_pkg::SIZE_FIELD_W-1:0]   in_size,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_granted,
  output logic [fpba_pkg::IDX_FIELD_W-1:0]         out_chosen_block,
  output logic [fpba_pkg::SIZE_FIELD_W-1:0]        out_remaining_after
);

  fpba_pkg::fpba_cmd_t cmd;
  fpba_pkg::fpba_sts_t sts;

  assign cfg_ready = 1'b1;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  fpba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_load_index       (in_load_index),
    .in_size             (in_size),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted         (out_granted),
    .out_chosen_block    (out_chosen_block),
    .out_remaining_after (out_remaining_after),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_wr, cmd.start, cmd.scan_rd, cmd.wb}))
    else $error("allocator: overlapping datapath commands");

  // an accepted allocate blocks the input until its result is written back
  a_alloc_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == fpba_pkg::OP_ALLOC)) |=> in_stall)
    else $error("allocator: input taken during an allocate");

  // a pending result beat is never overwritten by write back
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> !(out_valid && out_stall))
    else $error("allocator: write back over a pending result");

  // a refused request reports zero index and size
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_chosen_block == '0 && out_remaining_after == '0))
    else $error("allocator: refused result carries data");

endmodule

`default_nettype wire
